// ----- rtl/ocs_pkg.sv -----
package ocs_pkg;

  localparam int STORE_WORDS = 2048;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int WORD_W      = 16;

  localparam logic [15:0] W16  = 16'o177777;
  localparam logic [15:0] SIGN = 16'o100000;
  localparam logic [15:0] NEG1 = 16'o177776;

  localparam logic [10:0] START_RESET  = 11'd32;
  localparam logic [3:0]  UNITS_RESET  = 4'd2;

  // command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  localparam logic [1:0] CMD_EXEC  = 2'd3;

  // configuration register indexes
  localparam logic CFG_START = 1'b0;
  localparam logic CFG_UNITS = 1'b1;

  // alarm codes
  localparam logic [2:0] ALM_NONE     = 3'd0;
  localparam logic [2:0] ALM_OVERFLOW = 3'd1;
  localparam logic [2:0] ALM_DIVIDE   = 3'd2;
  localparam logic [2:0] ALM_CHECK    = 3'd3;
  localparam logic [2:0] ALM_INVALID  = 3'd4;

  // opcodes
  localparam logic [4:0] OP_SEL = 5'd0;
  localparam logic [4:0] OP_RD  = 5'd3;
  localparam logic [4:0] OP_RC  = 5'd5;
  localparam logic [4:0] OP_SD  = 5'd6;
  localparam logic [4:0] OP_TS  = 5'd8;
  localparam logic [4:0] OP_TD  = 5'd9;
  localparam logic [4:0] OP_TA  = 5'd10;
  localparam logic [4:0] OP_CK  = 5'd11;
  localparam logic [4:0] OP_AB  = 5'd12;
  localparam logic [4:0] OP_EX  = 5'd13;
  localparam logic [4:0] OP_CP  = 5'd14;
  localparam logic [4:0] OP_SP  = 5'd15;
  localparam logic [4:0] OP_CA  = 5'd16;
  localparam logic [4:0] OP_CS  = 5'd17;
  localparam logic [4:0] OP_AD  = 5'd18;
  localparam logic [4:0] OP_SU  = 5'd19;
  localparam logic [4:0] OP_CM  = 5'd20;
  localparam logic [4:0] OP_SA  = 5'd21;
  localparam logic [4:0] OP_AO  = 5'd22;
  localparam logic [4:0] OP_DM  = 5'd23;
  localparam logic [4:0] OP_MR  = 5'd24;
  localparam logic [4:0] OP_MH  = 5'd25;
  localparam logic [4:0] OP_DV  = 5'd26;
  localparam logic [4:0] OP_SL  = 5'd27;
  localparam logic [4:0] OP_SR  = 5'd28;
  localparam logic [4:0] OP_SF  = 5'd29;
  localparam logic [4:0] OP_CY  = 5'd30;
  localparam logic [4:0] OP_MD  = 5'd31;

  typedef struct packed {
    logic [1:0]  ovm;
    logic [15:0] sum;
  } add_res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [15:0] read_word;
    logic        running;
    logic [2:0]  alarm;
    logic        record_valid;
    logic [5:0]  record_char;
    logic [15:0] accumulator;
    logic [10:0] pc;
  } result_t;

  // ones'-complement add with end-around carry and overflow memory code
  function automatic add_res_t oc_add(logic [15:0] a, logic [15:0] x);
    add_res_t    res;
    logic [16:0] s;
    logic [15:0] c;
    logic [15:0] r;
    logic        v;
    s = {1'b0, a} + {1'b0, x};
    c = {1'b0, a[14:0]} + {1'b0, x[14:0]};
    r = s[15:0] + {15'd0, s[16]};
    v = s[16] ^ c[15];
    res.sum = r;
    res.ovm = v ? (r[15] ? 2'd2 : 2'd1) : 2'd0;
    return res;
  endfunction

  function automatic logic [15:0] oc_mag(logic [15:0] v);
    return v[15] ? ~v : v;
  endfunction

endpackage

// ----- rtl/ocs_ram.sv -----
module ocs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ocs_core.sv -----
module ocs_core import ocs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [1:0]  command,
  input  logic [10:0] address,
  input  logic [15:0] data,
  input  logic [5:0]  read_char,
  input  logic [10:0] start_address,
  input  logic [3:0]  attached_units,
  input  logic        res_take,
  output logic        idle,
  output logic        res_valid,
  output result_t     res,
  output mem_req_t    mem,
  input  logic [15:0] ram_rdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDW   = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_OPER  = 3'd3;
  localparam logic [2:0] ST_EXEC  = 3'd4;
  localparam logic [2:0] ST_ITER  = 3'd5;
  localparam logic [2:0] ST_FINAL = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]  state;
  logic [15:0] inst;
  logic [15:0] opnd;
  logic [5:0]  rchar;
  logic [15:0] acc;
  logic [15:0] b;
  logic [15:0] areg;
  logic [1:0]  ovm;
  logic [15:0] io;
  logic        tsel;
  logic [1:0]  tunit;
  logic        run;
  logic [10:0] pc;
  logic [5:0]  cnt;
  logic        neg;
  logic [15:0] rword;
  logic [2:0]  alarm;
  logic        recv;
  logic [5:0]  recc;

  logic [4:0]  op;
  logic [10:0] iaddr;
  logic        unit_ready;
  logic [15:0] opnd_mag;
  logic [15:0] acc_mag;
  logic [15:0] ca_init;
  logic [15:0] rd_word;
  logic [15:0] add_a;
  logic [15:0] add_x;
  add_res_t    ar;
  logic [15:0] mul_s;
  logic        round_en;
  logic [15:0] acc_rnd;
  logic        rnd_alarm;
  logic        iter_stop;

  assign op         = inst[15:11];
  assign iaddr      = inst[10:0];
  assign unit_ready = tsel && attached_units[tunit];
  assign opnd_mag   = oc_mag(opnd);
  assign acc_mag    = oc_mag(acc);
  assign ca_init    = (ovm == 2'd1) ? 16'd1 : ((ovm == 2'd2) ? NEG1 : 16'd0);
  assign rd_word    = io | (unit_ready ? {10'd0, rchar} : 16'd0);
  assign mul_s      = b[0] ? ar.sum : acc;
  assign round_en   = ((op inside {OP_SL, OP_SR}) && !iaddr[9]) || (op == OP_MR);
  assign acc_rnd    = (round_en && b[15]) ? ar.sum : acc;
  assign rnd_alarm  = round_en && (b[15] ? (ar.ovm != 2'd0)
                                         : ((op != OP_MR) && (ovm != 2'd0)));
  assign iter_stop  = (op == OP_SF) ? (acc[14] || cnt == 6'd33) : (cnt == 6'd0);

  // select the operands of the shared adder
  always_comb begin
    add_a = acc;
    add_x = opnd;
    case (state)
      ST_EXEC: begin
        case (op)
          OP_CA, OP_CS, OP_CM: begin
            add_a = ca_init;
            add_x = (op == OP_CS) ? ~opnd : ((op == OP_CM) ? opnd_mag : opnd);
          end
          OP_SU: add_x = ~opnd;
          OP_AB: add_a = b;
          OP_AO: begin
            add_a = opnd;
            add_x = 16'd1;
          end
          OP_DM, OP_DV: begin
            add_a = acc_mag;
            add_x = ~opnd_mag;
          end
          default: add_x = opnd;
        endcase
      end
      ST_ITER: add_x = (op == OP_DV && b[0]) ? ~areg : areg;
      ST_FINAL: add_x = 16'd1;
      default: add_x = opnd;
    endcase
  end

  assign ar = oc_add(add_a, add_x);

  // store port requests
  always_comb begin
    mem.we    = 1'b0;
    mem.waddr = iaddr;
    mem.wdata = acc;
    mem.raddr = pc;
    case (state)
      ST_IDLE: begin
        if (command == CMD_READ) begin
          mem.raddr = address;
        end
        if (go && command == CMD_LOAD) begin
          mem.we    = 1'b1;
          mem.waddr = address;
          mem.wdata = data;
        end
      end
      ST_FETCH: mem.raddr = ram_rdata[10:0];
      ST_EXEC: begin
        case (op)
          OP_TS, OP_EX: mem.we = 1'b1;
          OP_TD: begin
            mem.we    = 1'b1;
            mem.wdata = {opnd[15:11], acc[10:0]};
          end
          OP_TA: begin
            mem.we    = 1'b1;
            mem.wdata = {opnd[15:11], areg[10:0]};
          end
          OP_AB, OP_AO: begin
            mem.we    = ar.ovm == 2'd0 ? 1'b1 : 1'b1;
            mem.wdata = ar.sum;
          end
          default: mem.we = 1'b0;
        endcase
      end
      ST_FINAL: begin
        if (op == OP_SF) begin
          mem.we    = 1'b1;
          mem.wdata = {opnd[15:11], 5'd0, cnt};
        end
      end
      default: mem.we = 1'b0;
    endcase
  end

  // sequencer and machine registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      inst  <= '0;
      opnd  <= '0;
      rchar <= '0;
      acc   <= '0;
      b     <= '0;
      areg  <= '0;
      ovm   <= '0;
      io    <= '0;
      tsel  <= 1'b0;
      tunit <= '0;
      run   <= 1'b0;
      pc    <= '0;
      cnt   <= '0;
      neg   <= 1'b0;
      rword <= '0;
      alarm <= ALM_NONE;
      recv  <= 1'b0;
      recc  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (go) begin
            rword <= '0;
            alarm <= ALM_NONE;
            recv  <= 1'b0;
            recc  <= '0;
            rchar <= read_char;
            case (command)
              CMD_LOAD: state <= ST_DONE;
              CMD_READ: state <= ST_RDW;
              CMD_START: begin
                pc    <= start_address;
                run   <= 1'b1;
                state <= ST_DONE;
              end
              default: state <= run ? ST_FETCH : ST_DONE;
            endcase
          end
        end
        ST_RDW: begin
          rword <= ram_rdata;
          state <= ST_DONE;
        end
        ST_FETCH: begin
          inst  <= ram_rdata;
          pc    <= pc + 11'd1;
          state <= ST_OPER;
        end
        ST_OPER: begin
          opnd  <= ram_rdata;
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= ST_DONE;
          case (op)
            OP_SEL: begin
              if (iaddr <= 11'd1) begin
                run <= 1'b0;
              end else if (iaddr[8:6] == 3'd2) begin
                tsel  <= 1'b1;
                tunit <= iaddr[8:7];
              end
              io <= '0;
            end
            OP_RC: begin
              io <= acc;
              if (unit_ready) begin
                recv <= 1'b1;
                recc <= acc[15:10];
              end
            end
            OP_RD: begin
              areg <= rd_word;
              acc  <= rd_word;
              io   <= '0;
            end
            OP_CK: begin
              if (acc != opnd) begin
                alarm <= ALM_CHECK;
                run   <= 1'b0;
              end
            end
            OP_CA, OP_CS, OP_CM: begin
              areg <= (op == OP_CM) ? opnd_mag : opnd;
              b    <= '0;
              acc  <= ar.sum;
              ovm  <= '0;
              if (ar.ovm != 2'd0) begin
                alarm <= ALM_OVERFLOW;
                run   <= 1'b0;
              end
            end
            OP_SA: begin
              areg <= opnd;
              acc  <= ar.sum ^ ((ar.ovm != 2'd0) ? SIGN : 16'd0);
              ovm  <= ar.ovm;
            end
            OP_AD, OP_SU, OP_AB, OP_AO: begin
              areg <= opnd;
              acc  <= ar.sum;
              ovm  <= '0;
              if (ar.ovm != 2'd0) begin
                alarm <= ALM_OVERFLOW;
                run   <= 1'b0;
              end
            end
            OP_DM: begin
              areg <= opnd_mag;
              b    <= acc;
              acc  <= ar.sum;
              ovm  <= '0;
            end
            OP_TS, OP_TD, OP_TA: begin
              ovm <= ovm;
            end
            OP_EX: begin
              areg <= opnd;
              acc  <= opnd;
            end
            OP_SD: begin
              areg <= opnd;
              acc  <= acc ^ opnd;
              ovm  <= '0;
            end
            OP_MD: begin
              areg <= ~(acc & opnd);
              acc  <= acc & opnd;
            end
            OP_CP, OP_SP: begin
              areg <= {areg[15:11], pc};
              if (op == OP_SP || acc[15]) begin
                pc <= iaddr;
              end
            end
            OP_SL, OP_SR: begin
              neg   <= acc[15];
              acc   <= acc_mag;
              cnt   <= {1'b0, iaddr[4:0]};
              state <= ST_ITER;
            end
            OP_CY: begin
              cnt   <= {1'b0, iaddr[4:0]};
              state <= ST_ITER;
            end
            OP_SF: begin
              neg   <= acc[15];
              acc   <= acc_mag;
              cnt   <= '0;
              state <= ST_ITER;
            end
            OP_MR, OP_MH: begin
              neg   <= acc[15] ^ opnd[15];
              b     <= acc_mag;
              acc   <= '0;
              areg  <= opnd_mag;
              cnt   <= 6'd15;
              state <= ST_ITER;
            end
            OP_DV: begin
              neg  <= acc[15] ^ opnd[15];
              areg <= opnd_mag;
              ovm  <= ar.ovm;
              if (!ar.sum[15] || ar.sum == W16) begin
                // divisor too small: keep the trial difference and halt
                acc   <= ar.sum;
                alarm <= ALM_DIVIDE;
                run   <= 1'b0;
              end else begin
                b     <= {b[14:0], ~ar.sum[15]};
                acc   <= {ar.sum[14:0], ar.sum[15]};
                cnt   <= 6'd16;
                state <= ST_ITER;
              end
            end
            default: alarm <= ALM_INVALID;
          endcase
        end
        ST_ITER: begin
          if (iter_stop) begin
            state <= ST_FINAL;
          end else begin
            case (op)
              OP_SR: begin
                b   <= {acc[0], b[15:1]};
                acc <= {1'b0, acc[15:1]};
                cnt <= cnt - 6'd1;
              end
              OP_SL: begin
                acc <= {1'b0, acc[13:0], b[15]};
                b   <= {b[14:0], 1'b0};
                cnt <= cnt - 6'd1;
              end
              OP_CY: begin
                acc <= {acc[14:0], b[15]};
                b   <= {b[14:0], acc[15]};
                cnt <= cnt - 6'd1;
              end
              OP_SF: begin
                acc <= {acc[14:0], b[15]};
                b   <= {b[14:0], 1'b0};
                cnt <= cnt + 6'd1;
              end
              OP_MR, OP_MH: begin
                if (b[0]) begin
                  ovm <= ar.ovm;
                end
                b   <= {mul_s[0], b[15:1]};
                acc <= {1'b0, mul_s[15:1]};
                cnt <= cnt - 6'd1;
              end
              OP_DV: begin
                ovm <= ar.ovm;
                b   <= {b[14:0], ~ar.sum[15]};
                acc <= {ar.sum[14:0], ar.sum[15]};
                cnt <= cnt - 6'd1;
              end
              default: cnt <= '0;
            endcase
          end
        end
        ST_FINAL: begin
          state <= ST_DONE;
          case (op)
            OP_SL, OP_SR, OP_MR, OP_MH: begin
              if (round_en) begin
                b <= '0;
              end
              if (rnd_alarm) begin
                alarm <= ALM_OVERFLOW;
                run   <= 1'b0;
              end
              acc <= neg ? ~acc_rnd : acc_rnd;
              ovm <= '0;
            end
            OP_CY: begin
              if (!iaddr[9]) begin
                b <= '0;
              end
            end
            OP_SF: begin
              acc  <= neg ? ~acc : acc;
              ovm  <= '0;
              areg <= {10'd0, cnt};
            end
            OP_DV: begin
              acc <= {16{neg}};
              ovm <= '0;
            end
            default: ovm <= ovm;
          endcase
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_comb begin
    res.read_word    = rword;
    res.running      = run;
    res.alarm        = alarm;
    res.record_valid = recv;
    res.record_char  = recc;
    res.accumulator  = acc;
    res.pc           = pc;
  end

  // halting alarms leave the machine stopped
  assert property (@(posedge clk) disable iff (rst)
    res_valid && alarm != ALM_NONE && alarm != ALM_INVALID |-> !run)
    else $error("halting alarm with machine still running");

  // a character is only recorded from a selected tape unit
  assert property (@(posedge clk) disable iff (rst)
    res_valid && recv |-> tsel)
    else $error("record transfer without a selected unit");

  // store writes only come from accept, execute or finish steps
  assert property (@(posedge clk) disable iff (rst)
    mem.we |-> (state == ST_IDLE || state == ST_EXEC || state == ST_FINAL))
    else $error("store write from an unexpected step");

  // the step counter never runs past the scale limit
  assert property (@(posedge clk) disable iff (rst)
    state == ST_ITER |-> cnt <= 6'd33)
    else $error("step counter out of range");

endmodule

// ----- rtl/ones_complement_cpu_step.sv -----
// Execute steps through fetch, operand read and the shared adder; shift,
// cycle, scale, multiply and divide then run a loop of one step per cycle.
// Throughput: one item at a time; the next is taken once the result is staged.
// Reset: all machine registers clear; the store is then zeroed by a sweep of
// 2048 words during which no item is taken (configuration writes still work).
module ones_complement_cpu_step import ocs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [10:0] address,
  input  logic [15:0] data,
  input  logic [5:0]  read_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] read_word,
  output logic        running,
  output logic [2:0]  alarm,
  output logic        record_valid,
  output logic [5:0]  record_char,
  output logic [15:0] accumulator_out,
  output logic [10:0] pc_out,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  logic [10:0]       start_address;
  logic [3:0]        attached_units;
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic              core_idle;
  logic              res_valid;
  logic              res_take;
  logic              go;
  result_t           res;
  result_t           out_reg;
  mem_req_t          core_mem;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address  <= START_RESET;
      attached_units <= UNITS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_START: start_address  <= cfg_data;
        CFG_UNITS: attached_units <= cfg_data[3:0];
        default:   start_address  <= start_address;
      endcase
    end
  end

  // sweep the store to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(STORE_WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign in_stall = clearing || !core_idle;
  assign go       = in_valid && !in_stall;
  assign res_take = res_valid && (!out_valid || !out_stall);

  assign ram_we    = clearing ? 1'b1 : core_mem.we;
  assign ram_waddr = clearing ? clr_addr : core_mem.waddr;
  assign ram_wdata = clearing ? '0 : core_mem.wdata;

  ocs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(core_mem.raddr),
    .rdata(ram_rdata)
  );

  ocs_core u_core (
    .clk           (clk),
    .rst           (rst),
    .go            (go),
    .command       (command),
    .address       (address),
    .data          (data),
    .read_char     (read_char),
    .start_address (start_address),
    .attached_units(attached_units),
    .res_take      (res_take),
    .idle          (core_idle),
    .res_valid     (res_valid),
    .res           (res),
    .mem           (core_mem),
    .ram_rdata     (ram_rdata)
  );

  // output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_reg <= res;
    end
  end

  assign read_word       = out_reg.read_word;
  assign running         = out_reg.running;
  assign alarm           = out_reg.alarm;
  assign record_valid    = out_reg.record_valid;
  assign record_char     = out_reg.record_char;
  assign accumulator_out = out_reg.accumulator;
  assign pc_out          = out_reg.pc;

endmodule
